@@ design/nnd_pkg.sv @@
// Shared widths, register indexes and controller/datapath interface types.
package nnd_pkg;

    localparam int CFG_W   = 10;
    localparam int PIX_W   = 8;
    localparam int COORD_W = 9;
    localparam int ADDR_W  = 2;
    localparam int ACC_W   = 2 * CFG_W;
    localparam int DIV_STEPS = CFG_W;
    localparam int STEP_W  = $clog2(DIV_STEPS);

    localparam logic [ADDR_W-1:0] REG_SRC_W  = 2'd0;
    localparam logic [ADDR_W-1:0] REG_SRC_H  = 2'd1;
    localparam logic [ADDR_W-1:0] REG_MAX_TW = 2'd2;
    localparam logic [ADDR_W-1:0] REG_MAX_TH = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic load_mul;
        logic div_step;
        logic load_pick;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic emit;
        logic out_free;
    } t_stat;

endpackage

@@ design/nnd_ctrl.sv @@
// Controller state machine: accept, multiply, divide and reload sequencing.
module nnd_ctrl
    import nnd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_stat i_stat,
    output logic  o_ready,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_RUN  = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_LOAD = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                ready;

    assign ready   = (r_state == S_RUN) && i_stat.out_free;
    assign o_ready = ready;

    always_comb begin
        n_state        = r_state;
        n_step         = r_step;
        o_cmd          = '0;
        unique case (r_state)
            S_RUN: begin
                o_cmd.take = i_valid && ready;
                if (i_valid && ready && i_stat.emit) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.load_mul = 1'b1;
                n_step         = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load_pick = 1'b1;
                n_state         = S_RUN;
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

@@ design/nnd_datapath.sv @@
// Datapath: size registers, position counters, pick divider and output register.
module nnd_datapath
    import nnd_pkg::*;
#(
    parameter int unsigned MAX_SIDE = 512
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_W-1:0]   i_cfg_wr_data,
    input  logic [PIX_W-1:0]   i_pixel,
    input  logic               i_frame_start,
    input  logic               i_out_ready,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    output logic               o_out_valid,
    output logic [PIX_W-1:0]   o_out_pixel,
    output logic [COORD_W-1:0] o_out_col,
    output logic [COORD_W-1:0] o_out_row,
    output logic               o_out_last
);

    localparam int          LP_CAP = (MAX_SIDE > 1023) ? 1023 : MAX_SIDE;
    localparam logic [CFG_W-1:0] LP_MAX = LP_CAP[CFG_W-1:0];

    function automatic logic [CFG_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = CFG_W'(1);
        end else if (v > LP_MAX) begin
            res = LP_MAX;
        end
        return res;
    endfunction

    logic [CFG_W-1:0] r_src_w, r_src_h, r_max_tw, r_max_th;
    logic [CFG_W-1:0] r_src_col, r_src_row, r_tcol, r_trow, r_pick_col, r_pick_row;
    logic             r_done;
    logic [ACC_W-1:0] r_acc_c, r_acc_r;
    logic             r_row_ovf;
    logic             r_out_valid, r_out_last;
    logic [PIX_W-1:0] r_out_pixel;
    logic [CFG_W-1:0] r_out_col, r_out_row;

    logic [CFG_W-1:0] sw, sh, tw, th, mtw, mth;
    logic [CFG_W-1:0] e_src_col, e_src_row, e_tcol, e_trow, e_pick_col, e_pick_row;
    logic             e_done, emit, last;
    logic [CFG_W:0]   inc_src_col, inc_src_row, inc_tcol, inc_trow;
    logic [CFG_W-1:0] n_src_col, n_src_row, n_tcol, n_trow;
    logic             n_done;
    logic [CFG_W:0]   div_t_c, div_t_r, div_rem_c, div_rem_r;
    logic             div_ge_c, div_ge_r;
    logic [ACC_W-1:0] n_acc_c, n_acc_r;
    logic [ACC_W-1:0] mul_r;

    always_comb begin
        sw  = clamp_side(r_src_w);
        sh  = clamp_side(r_src_h);
        mtw = clamp_side(r_max_tw);
        mth = clamp_side(r_max_th);
        tw  = (mtw < sw) ? mtw : sw;
        th  = (mth < sh) ? mth : sh;
    end

    // A frame start restarts the frame before this pixel is looked at.
    always_comb begin
        e_src_col  = i_frame_start ? '0 : r_src_col;
        e_src_row  = i_frame_start ? '0 : r_src_row;
        e_tcol     = i_frame_start ? '0 : r_tcol;
        e_trow     = i_frame_start ? '0 : r_trow;
        e_pick_col = i_frame_start ? '0 : r_pick_col;
        e_pick_row = i_frame_start ? '0 : r_pick_row;
        e_done     = i_frame_start ? 1'b0 : r_done;
        emit = !e_done && (e_src_row == e_pick_row) && (e_src_col == e_pick_col);

        inc_tcol = {1'b0, e_tcol} + 1'b1;
        inc_trow = {1'b0, e_trow} + 1'b1;
        last = (inc_tcol >= {1'b0, tw}) && (inc_trow >= {1'b0, th});

        inc_src_col = {1'b0, e_src_col} + 1'b1;
        inc_src_row = {1'b0, e_src_row} + 1'b1;
        n_src_col = inc_src_col[CFG_W-1:0];
        n_src_row = e_src_row;
        if (inc_src_col >= {1'b0, sw}) begin
            n_src_col = '0;
            n_src_row = inc_src_row[CFG_W-1:0];
            if (inc_src_row >= {1'b0, sh}) begin
                n_src_row = '0;
            end
        end

        n_tcol = e_tcol;
        n_trow = e_trow;
        n_done = e_done;
        if (emit) begin
            n_tcol = inc_tcol[CFG_W-1:0];
            if (inc_tcol >= {1'b0, tw}) begin
                n_tcol = '0;
                n_trow = inc_trow[CFG_W-1:0];
                if (inc_trow >= {1'b0, th}) begin
                    n_trow = '0;
                    n_done = 1'b1;
                end
            end
        end
    end

    // Restoring division, one quotient bit per step; the quotient collects
    // in the low half of the accumulator as the remainder moves up.
    always_comb begin
        mul_r     = ACC_W'(r_trow) * ACC_W'(sh);
        div_t_c   = r_acc_c[ACC_W-1:CFG_W-1];
        div_t_r   = r_acc_r[ACC_W-1:CFG_W-1];
        div_ge_c  = div_t_c >= {1'b0, tw};
        div_ge_r  = div_t_r >= {1'b0, th};
        div_rem_c = div_ge_c ? (div_t_c - {1'b0, tw}) : div_t_c;
        div_rem_r = div_ge_r ? (div_t_r - {1'b0, th}) : div_t_r;
        n_acc_c   = {div_rem_c[CFG_W-1:0], r_acc_c[CFG_W-2:0], div_ge_c};
        n_acc_r   = {div_rem_r[CFG_W-1:0], r_acc_r[CFG_W-2:0], div_ge_r};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w     <= CFG_W'(1);
            r_src_h     <= CFG_W'(1);
            r_max_tw    <= CFG_W'(35);
            r_max_th    <= CFG_W'(30);
            r_src_col   <= '0;
            r_src_row   <= '0;
            r_tcol      <= '0;
            r_trow      <= '0;
            r_pick_col  <= '0;
            r_pick_row  <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_addr)
                    REG_SRC_W:  r_src_w  <= i_cfg_wr_data;
                    REG_SRC_H:  r_src_h  <= i_cfg_wr_data;
                    REG_MAX_TW: r_max_tw <= i_cfg_wr_data;
                    REG_MAX_TH: r_max_th <= i_cfg_wr_data;
                    default: ;
                endcase
            end
            if (i_cmd.take && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.take) begin
                r_src_col  <= n_src_col;
                r_src_row  <= n_src_row;
                r_tcol     <= n_tcol;
                r_trow     <= n_trow;
                r_done     <= n_done;
                r_pick_col <= e_pick_col;
                r_pick_row <= e_pick_row;
            end
            // A row pick of 1024 or more is never reached, so all ones stands for it.
            if (i_cmd.load_pick) begin
                r_pick_col <= r_acc_c[CFG_W-1:0];
                r_pick_row <= r_row_ovf ? '1 : r_acc_r[CFG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && emit) begin
            r_out_pixel <= i_pixel;
            r_out_col   <= e_tcol;
            r_out_row   <= e_trow;
            r_out_last  <= last;
        end
        if (i_cmd.load_mul) begin
            r_acc_c   <= ACC_W'(r_tcol) * ACC_W'(sw);
            r_acc_r   <= mul_r;
            r_row_ovf <= mul_r[ACC_W-1:CFG_W] >= th;
        end else if (i_cmd.div_step) begin
            r_acc_c <= n_acc_c;
            r_acc_r <= n_acc_r;
        end
    end

    assign o_stat.emit     = emit;
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_pixel     = r_out_pixel;
    assign o_out_col       = r_out_col[COORD_W-1:0];
    assign o_out_row       = r_out_row[COORD_W-1:0];
    assign o_out_last      = r_out_last;

endmodule

@@ design/nearest_neighbor_downscaler.sv @@
// Nearest-neighbour thumbnail downscaler: top level joining controller and datapath.
//
// Source pixels enter on the s_axis channel in raster order, one transaction per
// pixel; s_axis_tuser set marks the first pixel of a new image. Selected pixels
// leave on the m_axis channel with their thumbnail column and row, and m_axis_tlast
// marks the final thumbnail pixel of the image.
// Sizes must be written on the plain register port only while no pixel is in
// flight; the block does not enforce this. A result shows in the cycle after its
// pixel's transaction. Unselected pixels are taken at one per cycle unless the
// receiver stalls. A selected pixel occupies the block for the transaction, one
// multiply of the next thumbnail index by the source size, a 10-step
// shift-and-subtract division giving the next source position to pick and its load.
// After reset the sizes take their reset values, the frame starts at source
// pixel (0,0) and the output register is empty.
// While the receiver stalls with a result waiting, the result holds and no new
// pixel is taken.
module nearest_neighbor_downscaler
    import nnd_pkg::*;
#(
    parameter int unsigned MAX_SIDE = 512
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_W-1:0]   i_cfg_wr_data,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] pixel_value
    input  logic               s_axis_tuser,   // [0] frame_start
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [31:0]        m_axis_tdata,   // [7:0] thumb_pixel, [16:8] thumb_col,
                                               // [25:17] thumb_row, [31:26] zero
    output logic               m_axis_tlast    // last_pixel
);

    t_cmd               cmd;
    t_stat              stat;
    logic [PIX_W-1:0]   out_pixel;
    logic [COORD_W-1:0] out_col, out_row;

    nnd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_stat  (stat),
        .o_ready (s_axis_tready),
        .o_cmd   (cmd)
    );

    nnd_datapath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_pixel       (s_axis_tdata),
        .i_frame_start (s_axis_tuser),
        .i_out_ready   (m_axis_tready),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_out_valid   (m_axis_tvalid),
        .o_out_pixel   (out_pixel),
        .o_out_col     (out_col),
        .o_out_row     (out_row),
        .o_out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {6'b0, out_row, out_col, out_pixel};

endmodule

@@ design/nnd_checker.sv @@
// Port-level checker for the downscaler and its bind to the top level.
module nnd_checker
    import nnd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // The output register is empty straight after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result presented straight after reset");

    // A stalled result keeps its contents.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // A result only appears after a pixel transaction in the cycle before.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("result without a pixel transaction");

    // No pixel is taken while a result waits on a stalled receiver.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("pixel taken while output stalled");

endmodule

bind nearest_neighbor_downscaler nnd_checker u_nnd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
